FILE: rtl/thst_pkg.sv
// thst_pkg: shared constants and types for the safe hysteresis thermostat
// no dependencies; used by the interfaces, the config registers, the core and the top level
package thst_pkg;

  // default temperature width, 1/16 degree units
  localparam int TEMP_BITS_DEF = 16;

  // field widths fixed by the item format
  localparam int TIME_W   = 32;
  localparam int PERIOD_W = 16;
  localparam int FAULT_W  = 8;
  localparam int COUNT_W  = 8;
  localparam int BAND_W   = 15;
  localparam int CFG_IDX_W = 3;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_VALID     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VALID     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_TEMP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVERY_NEED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HARD_CUTOFF   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_HYST_BAND     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET        = 3'd7;

  // register reset values
  localparam int RST_SAMPLE_PERIOD = 100;
  localparam int RST_MIN_VALID     = -800;
  localparam int RST_MAX_VALID     = 8000;
  localparam int RST_RECOVERY_TEMP = 800;
  localparam int RST_RECOVERY_NEED = 5;
  localparam int RST_HARD_CUTOFF   = 4000;
  localparam int RST_HYST_BAND     = 80;
  localparam int RST_TARGET        = 3200;

  // shutdown reason codes
  typedef enum logic [1:0] {
    REASON_NONE     = 2'd0,
    REASON_INVALID  = 2'd1,
    REASON_OVERHEAT = 2'd2
  } reason_t;

endpackage

FILE: rtl/thst_in_if.sv
// thst_in_if: input channel carrying one temperature sample transaction
// depends on thst_pkg
interface thst_in_if #(
  parameter int TEMP_BITS = thst_pkg::TEMP_BITS_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic [thst_pkg::TIME_W-1:0]       now_ms;
  logic signed [TEMP_BITS-1:0]       sample_temp;
  logic [thst_pkg::FAULT_W-1:0]      sensor_fault;
  logic                              power_on;
  logic                              fault_latched;

  modport source (
    output valid, now_ms, sample_temp, sensor_fault, power_on, fault_latched,
    input  ready
  );
  modport sink (
    input  valid, now_ms, sample_temp, sensor_fault, power_on, fault_latched,
    output ready
  );
endinterface

FILE: rtl/thst_out_if.sv
// thst_out_if: result channel carrying one heater control transaction
// depends on thst_pkg
interface thst_out_if #(
  parameter int TEMP_BITS = thst_pkg::TEMP_BITS_DEF
) ();
  logic                              valid;
  logic                              ready;
  logic [1:0]                        shutdown_reason;
  logic                              sample_taken;
  logic                              clear_fault_request;
  logic                              heater_on;
  logic                              sensor_healthy;
  logic signed [TEMP_BITS-1:0]       current_temp;
  logic [thst_pkg::COUNT_W-1:0]      recovery_count;

  modport source (
    output valid, shutdown_reason, sample_taken, clear_fault_request, heater_on,
           sensor_healthy, current_temp, recovery_count,
    input  ready
  );
  modport sink (
    input  valid, shutdown_reason, sample_taken, clear_fault_request, heater_on,
           sensor_healthy, current_temp, recovery_count,
    output ready
  );
endinterface

FILE: rtl/thst_cfg_regs.sv
// thst_cfg_regs: configuration register file with plain write port
// depends on thst_pkg
module thst_cfg_regs #(
  parameter int TEMP_BITS = thst_pkg::TEMP_BITS_DEF,
  parameter int CFG_DW    = (TEMP_BITS > thst_pkg::PERIOD_W) ? TEMP_BITS : thst_pkg::PERIOD_W
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [thst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DW-1:0]                 cfg_data,
  output logic [thst_pkg::PERIOD_W-1:0]     sample_period,
  output logic signed [TEMP_BITS-1:0]       min_valid,
  output logic signed [TEMP_BITS-1:0]       max_valid,
  output logic signed [TEMP_BITS-1:0]       recovery_temp,
  output logic [thst_pkg::COUNT_W-1:0]      recovery_need,
  output logic signed [TEMP_BITS-1:0]       hard_cutoff,
  output logic [thst_pkg::BAND_W-1:0]       hyst_band,
  output logic signed [TEMP_BITS-1:0]       target
);

  logic [thst_pkg::PERIOD_W-1:0]  sample_period_r;
  logic signed [TEMP_BITS-1:0]    min_valid_r;
  logic signed [TEMP_BITS-1:0]    max_valid_r;
  logic signed [TEMP_BITS-1:0]    recovery_temp_r;
  logic [thst_pkg::COUNT_W-1:0]   recovery_need_r;
  logic signed [TEMP_BITS-1:0]    hard_cutoff_r;
  logic [thst_pkg::BAND_W-1:0]    hyst_band_r;
  logic signed [TEMP_BITS-1:0]    target_r;

  // register writes, each keeps the low bits of the data word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sample_period_r <= thst_pkg::PERIOD_W'(thst_pkg::RST_SAMPLE_PERIOD);
      min_valid_r     <= TEMP_BITS'(thst_pkg::RST_MIN_VALID);
      max_valid_r     <= TEMP_BITS'(thst_pkg::RST_MAX_VALID);
      recovery_temp_r <= TEMP_BITS'(thst_pkg::RST_RECOVERY_TEMP);
      recovery_need_r <= thst_pkg::COUNT_W'(thst_pkg::RST_RECOVERY_NEED);
      hard_cutoff_r   <= TEMP_BITS'(thst_pkg::RST_HARD_CUTOFF);
      hyst_band_r     <= thst_pkg::BAND_W'(thst_pkg::RST_HYST_BAND);
      target_r        <= TEMP_BITS'(thst_pkg::RST_TARGET);
    end else if (cfg_we) begin
      case (cfg_index)
        thst_pkg::REG_SAMPLE_PERIOD: sample_period_r <= cfg_data[thst_pkg::PERIOD_W-1:0];
        thst_pkg::REG_MIN_VALID:     min_valid_r     <= cfg_data[TEMP_BITS-1:0];
        thst_pkg::REG_MAX_VALID:     max_valid_r     <= cfg_data[TEMP_BITS-1:0];
        thst_pkg::REG_RECOVERY_TEMP: recovery_temp_r <= cfg_data[TEMP_BITS-1:0];
        thst_pkg::REG_RECOVERY_NEED: recovery_need_r <= cfg_data[thst_pkg::COUNT_W-1:0];
        thst_pkg::REG_HARD_CUTOFF:   hard_cutoff_r   <= cfg_data[TEMP_BITS-1:0];
        thst_pkg::REG_HYST_BAND:     hyst_band_r     <= cfg_data[thst_pkg::BAND_W-1:0];
        thst_pkg::REG_TARGET:        target_r        <= cfg_data[TEMP_BITS-1:0];
        default: ;
      endcase
    end
  end

  assign sample_period = sample_period_r;
  assign min_valid     = min_valid_r;
  assign max_valid     = max_valid_r;
  assign recovery_temp = recovery_temp_r;
  assign recovery_need = recovery_need_r;
  assign hard_cutoff   = hard_cutoff_r;
  assign hyst_band     = hyst_band_r;
  assign target        = target_r;

endmodule

FILE: rtl/thst_core.sv
// thst_core: input register, control decision, thermostat state and result register
// depends on thst_pkg, thst_in_if and thst_out_if
module thst_core #(
  parameter int TEMP_BITS = thst_pkg::TEMP_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  thst_in_if.sink                           in_ch,
  thst_out_if.source                        out_ch,
  input  logic [thst_pkg::PERIOD_W-1:0]     sample_period,
  input  logic signed [TEMP_BITS-1:0]       min_valid,
  input  logic signed [TEMP_BITS-1:0]       max_valid,
  input  logic signed [TEMP_BITS-1:0]       recovery_temp,
  input  logic [thst_pkg::COUNT_W-1:0]      recovery_need,
  input  logic signed [TEMP_BITS-1:0]       hard_cutoff,
  input  logic [thst_pkg::BAND_W-1:0]       hyst_band,
  input  logic signed [TEMP_BITS-1:0]       target
);

  // width of the heater-on threshold, wide enough that target minus band never wraps
  localparam int LOW_W = ((TEMP_BITS > thst_pkg::BAND_W) ? TEMP_BITS : thst_pkg::BAND_W) + 2;

  // input register
  logic                              in_vld_r;
  logic [thst_pkg::TIME_W-1:0]       now_r;
  logic signed [TEMP_BITS-1:0]       temp_r;
  logic [thst_pkg::FAULT_W-1:0]      fault_r;
  logic                              power_r;
  logic                              latched_r;

  // thermostat state
  logic [thst_pkg::TIME_W-1:0]       last_time_r, last_time_nxt;
  logic [thst_pkg::COUNT_W-1:0]      cnt_r, cnt_nxt;
  logic                              heater_r, heater_nxt;
  logic                              healthy_r, healthy_nxt;
  logic signed [TEMP_BITS-1:0]       last_temp_r, last_temp_nxt;

  // result register
  logic                              out_vld_r;
  thst_pkg::reason_t                 reason_r, reason_nxt;
  logic                              taken_r;
  logic                              clear_r;

  logic                              advance;
  logic                              fire;
  logic [thst_pkg::TIME_W-1:0]       elapsed;
  logic                              due;
  logic                              reading_ok;
  logic                              below_recovery;
  logic                              overheat;
  logic signed [LOW_W-1:0]           on_thresh;

  // handshake: the result register frees when empty or being taken
  assign advance     = !out_vld_r || out_ch.ready;
  assign fire        = in_vld_r && advance;
  assign in_ch.ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      now_r     <= in_ch.now_ms;
      temp_r    <= in_ch.sample_temp;
      fault_r   <= in_ch.sensor_fault;
      power_r   <= in_ch.power_on;
      latched_r <= in_ch.fault_latched;
    end
  end

  // due check on modular time, reading validity and thresholds
  assign elapsed        = now_r - last_time_r;
  assign due            = elapsed >= {{(thst_pkg::TIME_W - thst_pkg::PERIOD_W){1'b0}}, sample_period};
  assign reading_ok     = (fault_r == '0) && (temp_r >= min_valid) && (temp_r <= max_valid);
  assign below_recovery = temp_r < recovery_temp;
  assign overheat       = temp_r >= hard_cutoff;
  assign on_thresh      = LOW_W'(target) - $signed(LOW_W'(hyst_band));

  // next state of the thermostat
  always_comb begin
    last_time_nxt = last_time_r;
    cnt_nxt       = cnt_r;
    heater_nxt    = heater_r;
    healthy_nxt   = healthy_r;
    last_temp_nxt = last_temp_r;
    reason_nxt    = thst_pkg::REASON_NONE;
    if (due) begin
      last_time_nxt = now_r;
      healthy_nxt   = reading_ok;
      if (!reading_ok) begin
        cnt_nxt    = '0;
        heater_nxt = 1'b0;
        reason_nxt = thst_pkg::REASON_INVALID;
      end else begin
        last_temp_nxt = temp_r;
        // saturating count of cool readings
        if (below_recovery) begin
          if (cnt_r < recovery_need) begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end else begin
          cnt_nxt = '0;
        end
        // interlocks first, then hysteresis
        if (overheat) begin
          heater_nxt = 1'b0;
          reason_nxt = thst_pkg::REASON_OVERHEAT;
        end else if (!power_r || latched_r) begin
          heater_nxt = 1'b0;
        end else if (LOW_W'(temp_r) < on_thresh) begin
          heater_nxt = 1'b1;
        end else if (temp_r >= target) begin
          heater_nxt = 1'b0;
        end
      end
    end
  end

  // state update with each processed transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_time_r <= '0;
      cnt_r       <= '0;
      heater_r    <= 1'b0;
      healthy_r   <= 1'b0;
      last_temp_r <= '0;
    end else if (fire) begin
      last_time_r <= last_time_nxt;
      cnt_r       <= cnt_nxt;
      heater_r    <= heater_nxt;
      healthy_r   <= healthy_nxt;
      last_temp_r <= last_temp_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      reason_r <= reason_nxt;
      taken_r  <= due;
      clear_r  <= due && (fault_r != '0);
    end
  end

  assign out_ch.valid               = out_vld_r;
  assign out_ch.shutdown_reason     = reason_r;
  assign out_ch.sample_taken        = taken_r;
  assign out_ch.clear_fault_request = clear_r;
  assign out_ch.heater_on           = heater_r;
  assign out_ch.sensor_healthy      = healthy_r;
  assign out_ch.current_temp        = last_temp_r;
  assign out_ch.recovery_count      = cnt_r;

  // heater only runs after a valid reading
  a_heater_needs_health: assert property (@(posedge clk) disable iff (!rst_n)
    heater_r |-> healthy_r)
    else $error("heater on with unhealthy sensor");

  // an invalid due reading clears the recovery counter and the heater
  a_invalid_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && due && !reading_ok) |=> (cnt_r == '0) && !heater_r)
    else $error("invalid reading did not clear state");

  // a fault clear request always comes with a sensor invalid reason
  a_clear_reason: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && clear_r) |-> (taken_r && (reason_r == thst_pkg::REASON_INVALID)))
    else $error("clear request without invalid reason");

  // overheat leaves the heater off
  a_overheat_off: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (reason_r == thst_pkg::REASON_OVERHEAT)) |-> !heater_r)
    else $error("heater on after overheat");

endmodule

FILE: rtl/safe_hysteresis_thermostat_top.sv
// safe_hysteresis_thermostat_top: top level of the hysteresis thermostat with interlocks
// depends on thst_pkg, thst_in_if, thst_out_if, thst_cfg_regs and thst_core
//
// usage
//   in_ch carries one sample transaction (time, temperature, fault byte, power and
//   latched-fault flags); out_ch returns exactly one control transaction per sample.
//   cfg_we / cfg_index / cfg_data write the eight control registers, one per cycle;
//   the user must write them only while no transaction is in flight (not enforced).
// pipeline and throughput
//   a sample accepted into the input register is decided in one pass of compare
//   logic and shown on out_ch from the result register. one transaction per cycle
//   is sustained while out_ch.ready stays high; the rate is set by the single
//   decision stage between the input register and the result register.
// stalls
//   while out_ch.ready is low the result register holds, one more sample waits in
//   the input register, and in_ch.ready drops only when both are full.
// reset
//   rst_n low clears both channel valid flags, the sample time, the recovery counter,
//   heater, health flag and last temperature, and loads the register defaults.
module safe_hysteresis_thermostat_top #(
  parameter int TEMP_BITS = thst_pkg::TEMP_BITS_DEF,
  parameter int CFG_DW    = (TEMP_BITS > thst_pkg::PERIOD_W) ? TEMP_BITS : thst_pkg::PERIOD_W
) (
  input  logic                              clk,
  input  logic                              rst_n,
  thst_in_if.sink                           in_ch,
  thst_out_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [thst_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DW-1:0]                 cfg_data
);

  logic [thst_pkg::PERIOD_W-1:0]  sample_period;
  logic signed [TEMP_BITS-1:0]    min_valid;
  logic signed [TEMP_BITS-1:0]    max_valid;
  logic signed [TEMP_BITS-1:0]    recovery_temp;
  logic [thst_pkg::COUNT_W-1:0]   recovery_need;
  logic signed [TEMP_BITS-1:0]    hard_cutoff;
  logic [thst_pkg::BAND_W-1:0]    hyst_band;
  logic signed [TEMP_BITS-1:0]    target;

  // control registers
  thst_cfg_regs #(
    .TEMP_BITS (TEMP_BITS),
    .CFG_DW    (CFG_DW)
  ) u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .sample_period (sample_period),
    .min_valid     (min_valid),
    .max_valid     (max_valid),
    .recovery_temp (recovery_temp),
    .recovery_need (recovery_need),
    .hard_cutoff   (hard_cutoff),
    .hyst_band     (hyst_band),
    .target        (target)
  );

  // decision pipeline and thermostat state
  thst_core #(
    .TEMP_BITS (TEMP_BITS)
  ) u_core (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .sample_period (sample_period),
    .min_valid     (min_valid),
    .max_valid     (max_valid),
    .recovery_temp (recovery_temp),
    .recovery_need (recovery_need),
    .hard_cutoff   (hard_cutoff),
    .hyst_band     (hyst_band),
    .target        (target)
  );

endmodule
